FILE: hdl/opd_pkg.sv
`timescale 1ns / 1ps
package opd_pkg;

  localparam int DATA_W      = 8;
  localparam int POS_W       = 23;
  localparam int PKT_W       = 26;
  localparam int PAGE_W      = 13;
  localparam int LACE_DEPTH  = 255;
  localparam int LACE_AW     = 8;
  localparam int HOFF_W      = 5;
  localparam int CFG_W       = 26;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  localparam logic [PAGE_W-1:0] MAX_PAGES        = PAGE_W'(4096);
  localparam logic [HOFF_W-1:0] HDR_BYTES        = HOFF_W'(27);
  localparam logic [HOFF_W-1:0] SEG_COUNT_OFFSET = HOFF_W'(26);
  localparam logic [HOFF_W-1:0] SIG_BYTES        = HOFF_W'(4);
  localparam logic [7:0]        FULL_LACE        = 8'd255;
  localparam logic [PKT_W-1:0]  VORBIS_LEN       = PKT_W'(7);
  localparam logic [PKT_W-1:0]  OPUS_LEN         = PKT_W'(8);

  localparam logic [CFG_W-1:0] MAX_PACKET_RESET = CFG_W'(32 << 20);
  localparam logic [POS_W-1:0] SCAN_LIMIT_RESET = POS_W'(256 << 10);

  localparam logic CFG_MAX_PACKET = 1'b0;
  localparam logic CFG_SCAN_LIMIT = 1'b1;

  localparam logic [1:0] KIND_OTHER  = 2'd0;
  localparam logic [1:0] KIND_VORBIS = 2'd1;
  localparam logic [1:0] KIND_OPUS   = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_SIG = 2'd1;
  localparam logic [1:0] ST_TOO_BIG = 2'd2;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [POS_W-1:0]  pos;
  } opd_item_t;

  typedef struct packed {
    logic              any;
    logic [DATA_W-1:0] data;
    logic              valid;
    logic              pend;
    logic [1:0]        kind;
    logic [1:0]        status;
  } opd_result_t;

  function automatic logic [7:0] capture_byte(input logic [1:0] i);
    logic [7:0] r;
    case (i)
      2'd0:    r = 8'h4F;
      2'd1:    r = 8'h67;
      2'd2:    r = 8'h67;
      default: r = 8'h53;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] vorbis_byte(input logic [2:0] i);
    logic [7:0] r;
    case (i)
      3'd0:    r = 8'h03;
      3'd1:    r = 8'h76;
      3'd2:    r = 8'h6F;
      3'd3:    r = 8'h72;
      3'd4:    r = 8'h62;
      3'd5:    r = 8'h69;
      default: r = 8'h73;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] opus_byte(input logic [2:0] i);
    logic [7:0] r;
    case (i)
      3'd0:    r = 8'h4F;
      3'd1:    r = 8'h70;
      3'd2:    r = 8'h75;
      3'd3:    r = 8'h73;
      3'd4:    r = 8'h54;
      3'd5:    r = 8'h61;
      3'd6:    r = 8'h67;
      default: r = 8'h73;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] packet_kind_of(input logic vm, input logic om,
                                                input logic [PKT_W-1:0] len);
    logic [1:0] k;
    k = KIND_OTHER;
    if (vm && len >= VORBIS_LEN) k = KIND_VORBIS;
    else if (om && len >= OPUS_LEN) k = KIND_OPUS;
    return k;
  endfunction

endpackage

FILE: hdl/opd_front.sv
`timescale 1ns / 1ps
module opd_front import opd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [DATA_W-1:0] data_byte,
  input  logic [POS_W-1:0]  scan_limit,
  input  logic              q_full,
  output logic              q_push,
  output opd_item_t         q_item
);

  logic [POS_W-1:0] bytes_seen;
  logic             accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  // bytes at or beyond the scan window are dropped here
  assign q_push   = accept && (bytes_seen < scan_limit);
  assign q_item   = '{data: data_byte, pos: bytes_seen};

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen <= '0;
    end else if (q_push) begin
      bytes_seen <= bytes_seen + POS_W'(1);
    end
  end

endmodule

FILE: hdl/opd_queue.sv
`timescale 1ns / 1ps
module opd_queue import opd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  opd_item_t push_item,
  output logic      full,
  input  logic      pop,
  output opd_item_t pop_item,
  output logic      empty
);

  opd_item_t               slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]     wr_ptr;
  logic [QUEUE_AW-1:0]     rd_ptr;
  logic [QUEUE_AW:0]       count;
  logic                    do_push;
  logic                    do_pop;

  assign full     = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + QUEUE_AW'(1);
      if (do_pop)  rd_ptr <= rd_ptr + QUEUE_AW'(1);
      if (do_push && !do_pop) count <= count + (QUEUE_AW+1)'(1);
      else if (do_pop && !do_push) count <= count - (QUEUE_AW+1)'(1);
    end
  end

endmodule

FILE: hdl/opd_back.sv
`timescale 1ns / 1ps
module opd_back import opd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [CFG_W-1:0]  max_packet,
  input  logic [POS_W-1:0]  scan_limit,
  input  logic              q_empty,
  input  opd_item_t         q_item,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] payload_byte,
  output logic              byte_valid,
  output logic              packet_end,
  output logic [1:0]        packet_kind,
  output logic [1:0]        status
);

  typedef enum logic [5:0] {
    M_HDR   = 6'b000001,
    M_LACE  = 6'b000010,
    M_DATA  = 6'b000100,
    M_OPRD  = 6'b001000,
    M_OPEN  = 6'b010000,
    M_QUIET = 6'b100000
  } mode_t;

  mode_t             mode, mode_next;
  logic [HOFF_W-1:0] hoff, hoff_next;
  logic [7:0]        seg_count, seg_count_next;
  logic [7:0]        seg_idx, seg_idx_next;
  logic [7:0]        seg_left, seg_left_next;
  logic [7:0]        seg_len, seg_len_next;
  logic [PKT_W-1:0]  pkt_len, pkt_len_next;
  logic              vmatch, vmatch_next;
  logic              omatch, omatch_next;
  logic [PAGE_W-1:0] page_cnt, page_cnt_next;
  logic [POS_W-1:0]  data_at, data_at_next;
  opd_result_t       acc, acc_next;
  opd_result_t       res;
  logic              emit;

  logic [7:0]        lace_mem [LACE_DEPTH];
  logic [7:0]        lace_rd;
  logic              mem_we;
  logic [LACE_AW-1:0] mem_wa;

  logic              out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      lace_mem[mem_wa] <= q_item.data;
    end
    lace_rd <= lace_mem[seg_idx];
  end

  always_comb begin
    logic [DATA_W-1:0] b;
    logic [POS_W-1:0]  pos;
    logic [POS_W:0]    pos_ext;
    logic [1:0]        kind;
    logic              vm_n;
    logic              om_n;
    logic [PKT_W-1:0]  pl_n;
    logic [7:0]        idx_n;

    b       = q_item.data;
    pos     = q_item.pos;
    pos_ext = {1'b0, pos};
    kind    = KIND_OTHER;
    vm_n    = vmatch;
    om_n    = omatch;
    pl_n    = pkt_len;
    idx_n   = seg_idx;

    mode_next      = mode;
    hoff_next      = hoff;
    seg_count_next = seg_count;
    seg_idx_next   = seg_idx;
    seg_left_next  = seg_left;
    seg_len_next   = seg_len;
    pkt_len_next   = pkt_len;
    vmatch_next    = vmatch;
    omatch_next    = omatch;
    page_cnt_next  = page_cnt;
    data_at_next   = data_at;
    res            = acc;
    emit           = 1'b0;
    q_pop          = 1'b0;
    mem_we         = 1'b0;
    mem_wa         = seg_idx;

    unique case (mode)
      M_QUIET: begin
        q_pop = !q_empty;
      end
      M_HDR: begin
        if (!q_empty && out_free) begin
          q_pop = 1'b1;
          if (hoff == '0 && (page_cnt >= MAX_PAGES ||
              pos_ext + (POS_W+1)'(HDR_BYTES) > {1'b0, scan_limit})) begin
            mode_next = M_QUIET;
          end else begin
            if (hoff == '0) page_cnt_next = page_cnt + PAGE_W'(1);
            if (hoff < SIG_BYTES && b != capture_byte(hoff[1:0])) begin
              res.any    = 1'b1;
              res.status = ST_BAD_SIG;
              emit       = 1'b1;
              mode_next  = M_QUIET;
            end else if (hoff >= SEG_COUNT_OFFSET) begin
              hoff_next      = '0;
              seg_count_next = b;
              seg_idx_next   = '0;
              if (pos_ext + (POS_W+1)'(1) + (POS_W+1)'(b) > {1'b0, scan_limit}) begin
                mode_next = M_QUIET;
              end else if (b != 8'd0) begin
                mode_next = M_LACE;
              end
            end else begin
              hoff_next = hoff + HOFF_W'(1);
            end
          end
        end
      end
      M_LACE: begin
        if (!q_empty && out_free) begin
          q_pop  = 1'b1;
          mem_we = 1'b1;
          idx_n  = seg_idx + 8'd1;
          if (idx_n >= seg_count) begin
            seg_idx_next = '0;
            data_at_next = pos + POS_W'(1);
            mode_next    = M_OPRD;
          end else begin
            seg_idx_next = idx_n;
          end
        end
      end
      M_DATA: begin
        if (!q_empty && out_free) begin
          q_pop      = 1'b1;
          res.any    = 1'b1;
          res.valid  = 1'b1;
          res.data   = b;
          if (pkt_len < VORBIS_LEN && b != vorbis_byte(pkt_len[2:0])) vm_n = 1'b0;
          if (pkt_len < OPUS_LEN && b != opus_byte(pkt_len[2:0])) om_n = 1'b0;
          pl_n          = pkt_len + PKT_W'(1);
          vmatch_next   = vm_n;
          omatch_next   = om_n;
          pkt_len_next  = pl_n;
          seg_left_next = seg_left - 8'd1;
          if (seg_left == 8'd1) begin
            seg_idx_next = seg_idx + 8'd1;
            data_at_next = pos + POS_W'(1);
            mode_next    = M_OPRD;
            if (seg_len < FULL_LACE) begin
              kind         = packet_kind_of(vm_n, om_n, pl_n);
              res.pend     = 1'b1;
              res.kind     = kind;
              pkt_len_next = '0;
              vmatch_next  = 1'b1;
              omatch_next  = 1'b1;
              if (kind != KIND_OTHER) begin
                mode_next = M_QUIET;
                emit      = 1'b1;
              end
            end
          end else begin
            emit = 1'b1;
          end
        end
      end
      M_OPRD: begin
        mode_next = M_OPEN;
      end
      M_OPEN: begin
        if (seg_idx >= seg_count) begin
          mode_next = M_HDR;
          hoff_next = '0;
          emit      = 1'b1;
        end else if ({1'b0, data_at} + (POS_W+1)'(lace_rd) > {1'b0, scan_limit}) begin
          mode_next = M_QUIET;
          emit      = 1'b1;
        end else if ({1'b0, pkt_len} + (PKT_W+1)'(lace_rd) > {1'b0, max_packet}) begin
          res.any    = 1'b1;
          res.status = ST_TOO_BIG;
          mode_next  = M_QUIET;
          emit       = 1'b1;
        end else if (lace_rd != 8'd0) begin
          seg_left_next = lace_rd;
          seg_len_next  = lace_rd;
          mode_next     = M_DATA;
          emit          = 1'b1;
        end else begin
          seg_idx_next = seg_idx + 8'd1;
          mode_next    = M_OPRD;
          if (pkt_len != '0) begin
            kind     = packet_kind_of(vmatch, omatch, pkt_len);
            res.any  = 1'b1;
            res.pend = 1'b1;
            res.kind = kind;
          end
          pkt_len_next = '0;
          vmatch_next  = 1'b1;
          omatch_next  = 1'b1;
          if (kind != KIND_OTHER) begin
            mode_next = M_QUIET;
            emit      = 1'b1;
          end
        end
      end
      default: begin
        mode_next = M_QUIET;
      end
    endcase

    acc_next = emit ? '0 : res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= M_HDR;
      hoff     <= '0;
      seg_count <= '0;
      seg_idx  <= '0;
      seg_left <= '0;
      seg_len  <= '0;
      pkt_len  <= '0;
      vmatch   <= 1'b1;
      omatch   <= 1'b1;
      page_cnt <= '0;
      data_at  <= '0;
      acc      <= '0;
      out_valid <= 1'b0;
    end else begin
      mode      <= mode_next;
      hoff      <= hoff_next;
      seg_count <= seg_count_next;
      seg_idx   <= seg_idx_next;
      seg_left  <= seg_left_next;
      seg_len   <= seg_len_next;
      pkt_len   <= pkt_len_next;
      vmatch    <= vmatch_next;
      omatch    <= omatch_next;
      page_cnt  <= page_cnt_next;
      data_at   <= data_at_next;
      acc       <= acc_next;
      if (emit && res.any) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit && res.any) begin
      payload_byte <= res.data;
      byte_valid   <= res.valid;
      packet_end   <= res.pend;
      packet_kind  <= res.kind;
      status       <= res.status;
    end
  end

  a_quiet_sticky: assert property (@(posedge clk) disable iff (rst)
    mode == M_QUIET |=> mode == M_QUIET)
    else $error("quiet mode left without reset");

  a_no_pop_while_opening: assert property (@(posedge clk) disable iff (rst)
    (mode == M_OPRD || mode == M_OPEN) |-> !q_pop)
    else $error("beat taken while opening segments");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (emit && res.any) |-> (!out_valid || out_ready))
    else $error("result register overwritten");

  a_data_has_bytes: assert property (@(posedge clk) disable iff (rst)
    mode == M_DATA |-> seg_left != 8'd0)
    else $error("data mode with empty segment");

endmodule

FILE: hdl/ogg_page_packet_deframer.sv
`timescale 1ns / 1ps
// a payload beat is written into a queue slot and registered again at the output
// throughput: one beat per cycle inside a segment and in headers and lacing tables
// unless out_ready stalls the output; at each segment boundary and page end the back
// end steps through M_OPRD and M_OPEN per lacing entry it opens (registered read of
// the lacing table); the 4-entry queue takes up the gap until full, then in_ready drops
// reset: synchronous, active high; state registers return to defaults, no clearing pass
module ogg_page_packet_deframer import opd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [DATA_W-1:0] data_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] payload_byte,
  output logic              byte_valid,
  output logic              packet_end,
  output logic [1:0]        packet_kind,
  output logic [1:0]        status,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  logic [CFG_W-1:0] max_packet;
  logic [POS_W-1:0] scan_limit;
  logic             q_push;
  logic             q_full;
  logic             q_pop;
  logic             q_empty;
  opd_item_t        push_item;
  opd_item_t        pop_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_packet <= MAX_PACKET_RESET;
      scan_limit <= SCAN_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_PACKET: max_packet <= cfg_data;
        CFG_SCAN_LIMIT: scan_limit <= cfg_data[POS_W-1:0];
        default:        max_packet <= max_packet;
      endcase
    end
  end

  opd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .scan_limit (scan_limit),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_item     (push_item)
  );

  opd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .empty     (q_empty)
  );

  opd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .max_packet   (max_packet),
    .scan_limit   (scan_limit),
    .q_empty      (q_empty),
    .q_item       (pop_item),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .payload_byte (payload_byte),
    .byte_valid   (byte_valid),
    .packet_end   (packet_end),
    .packet_kind  (packet_kind),
    .status       (status)
  );

endmodule
